// ----- sv/hogih_pkg.sv -----
// ----------------------------------------------------------------------------
// HOG integral histogram package
// Shared sizes, the CORDIC angle table, the front-to-back vote record and
// the saturating adder.
// ----------------------------------------------------------------------------
package hogih_pkg;

  localparam int BINS         = 9;
  localparam int MAX_WIDTH    = 1024;
  localparam int K_W          = $clog2(BINS);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = COL_W + 1;
  localparam int DEPTH        = BINS * MAX_WIDTH;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int SUM_W        = 32;
  localparam int VOTE_W       = 10;
  localparam int MAG_W        = 24;
  localparam int ANG_W        = 16;
  localparam int POS_W        = ANG_W + $clog2(2 * BINS);
  localparam int CORDIC_STEPS = 14;
  localparam int SQRT_STEPS   = 24;
  localparam int GRAD_ZERO    = 127;
  localparam int RECIP        = 1032;
  localparam int RECIP_SH     = 17;
  localparam int BIN_IDX_W    = 4;

  typedef struct packed {
    logic [K_W-1:0]    lo;
    logic [K_W-1:0]    hi;
    logic [VOTE_W-1:0] vote_lo;
    logic [VOTE_W-1:0] vote_hi;
    logic              frame_start;
  } hogih_vote_t;

  function automatic logic [13:0] cordic_atan(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ----- sv/hogih_if.sv -----
// ----------------------------------------------------------------------------
// HOG integral histogram stream interfaces
// Gradient pixel channel and per-bin integral result channel.
// ----------------------------------------------------------------------------
interface hogih_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] grad_x;
  logic [7:0] grad_y;
  logic       frame_start;
  modport source (output valid, grad_x, grad_y, frame_start, input ready);
  modport sink (input valid, grad_x, grad_y, frame_start, output ready);
endinterface

interface hogih_bin_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bin_index;
  logic [31:0] integral_sum;
  logic        last_bin;
  modport source (output valid, bin_index, integral_sum, last_bin, input ready);
  modport sink (input valid, bin_index, integral_sum, last_bin, output ready);
endinterface

// ----- sv/hog_orientation_integral_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// HOG orientation integral histogram unit
// Per gradient pixel, one saturating integral histogram value for every bin.
// ----------------------------------------------------------------------------
// Each accepted pixel passes through the front end in order: an accept state,
// the bit-serial square root (the 14 CORDIC angle steps run beside it), a
// position state, then a multiply and two divide states for each of the two
// votes, and a hand-over state for the record. The back end takes the record
// from the queue and then, per bin, reads the line store and updates and
// writes it. It runs beside the front end through a two-entry queue, so the
// front end can take a new pixel before the back end is through with the last
// one. The line store needs no clearing pass: on the first row of a frame its
// read data is ignored.
module hog_orientation_integral_histogram_unit (
  input  logic        clk,
  input  logic        rst,
  hogih_pix_if.sink   pixel,
  hogih_bin_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hogih_pkg::*;

  localparam logic [1:0] REG_SIGNED = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  logic        signed_mode;
  logic [15:0] angle_offset;
  logic [10:0] image_width;
  logic        cfg_we;

  logic        push_valid;
  logic        push_ready;
  hogih_vote_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  hogih_vote_t pop_item;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode  <= 1'b0;
      angle_offset <= 16'd0;
      image_width  <= 11'd640;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SIGNED: signed_mode  <= pwdata[0];
        REG_OFFSET: angle_offset <= pwdata[15:0];
        REG_WIDTH:  image_width  <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIGNED: prdata = {31'b0, signed_mode};
      REG_OFFSET: prdata = {16'b0, angle_offset};
      REG_WIDTH:  prdata = {21'b0, image_width};
      default:    prdata = 32'b0;
    endcase
  end

  hogih_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .signed_mode  (signed_mode),
    .angle_offset (angle_offset),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  hogih_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hogih_back u_back (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .result      (result)
  );

`ifndef ASSERT_OFF
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (int'(result.bin_index) < BINS))
    else $error("bin index out of range");

  a_last_bin: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.last_bin == (int'(result.bin_index) == BINS - 1)))
    else $error("last bin flag does not match bin index");

  a_vote_pair: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> ((int'(pop_item.lo) < BINS) &&
                   (pop_item.hi == ((pop_item.lo == K_W'(BINS - 1)) ? '0
                                                   : pop_item.lo + 1'b1))))
    else $error("vote bins are not neighbors");
`endif

endmodule

// ----- sv/hogih_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hogih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hogih_front.sv -----
// ----------------------------------------------------------------------------
// HOG integral histogram front end
// Takes a gradient pixel, finds its angle by CORDIC and its magnitude by a
// bit-serial square root, and forms the two interpolated bin votes.
// ----------------------------------------------------------------------------
module hogih_front (
  input  logic                  clk,
  input  logic                  rst,
  hogih_pix_if.sink             pixel,
  input  logic                  signed_mode,
  input  logic [15:0]           angle_offset,
  output logic                  push_valid,
  input  logic                  push_ready,
  output hogih_pkg::hogih_vote_t push_item
);
  import hogih_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ITER = 3'd1;
  localparam logic [2:0] F_POS  = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_DIV1 = 3'd4;
  localparam logic [2:0] F_DIV2 = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  function automatic logic signed [26:0] shr(input logic signed [26:0] v,
                                             input logic [3:0] sh);
    logic signed [26:0] r;
    if (v < 0) begin
      r = -((-v) >>> sh);
    end else begin
      r = v >>> sh;
    end
    return r;
  endfunction

  logic [2:0]           state;
  logic signed [26:0]   x;
  logic signed [26:0]   y;
  logic signed [16:0]   z;
  logic                 base;
  logic                 spec;
  logic [ANG_W-1:0]     spec_ang;
  logic [4:0]           cnt;
  logic [47:0]          rem;
  logic [47:0]          root;
  logic [K_W-1:0]       lo;
  logic [15:0]          f;
  logic                 sel;
  logic [40:0]          pa;
  logic [16:0]          a;
  logic [VOTE_W-1:0]    q0;
  logic [VOTE_W-1:0]    vote_lo;
  logic [VOTE_W-1:0]    vote_hi;
  logic                 fs;

  logic signed [8:0]    dx_in;
  logic signed [8:0]    dy_in;
  logic [15:0]          d2;
  logic signed [26:0]   xi;
  logic signed [26:0]   yi;
  logic signed [26:0]   sx;
  logic signed [26:0]   sy;
  logic signed [16:0]   at;
  logic [47:0]          bitv;
  logic [47:0]          tryv;
  logic [ANG_W-1:0]     ang;
  logic [ANG_W-1:0]     t;
  logic [POS_W-1:0]     posv;
  logic [POS_W-ANG_W-1:0] qb;
  logic [16:0]          wgt;
  logic [16:0]          av;
  logic [16:0]          rr;
  logic [VOTE_W-1:0]    vote;
  logic [K_W-1:0]       hi;

  assign dx_in = $signed({1'b0, pixel.grad_x}) - 9'sd127;
  assign dy_in = $signed({1'b0, pixel.grad_y}) - 9'sd127;
  assign d2    = 16'(dx_in * dx_in + dy_in * dy_in);
  assign xi    = 27'(dx_in) <<< 16;
  assign yi    = 27'(dy_in) <<< 16;
  assign sx    = shr(x, cnt[3:0]);
  assign sy    = shr(y, cnt[3:0]);
  assign at    = $signed({3'b0, cordic_atan(cnt[3:0])});
  assign bitv  = 48'(1) << (6'd46 - {cnt, 1'b0});
  assign tryv  = root + bitv;
  assign ang   = spec ? spec_ang : ({base, 15'b0} + z[15:0]);
  assign t     = ang + angle_offset + (signed_mode ? 16'h8000 : 16'h0000);
  assign posv  = POS_W'(t) * POS_W'(signed_mode ? BINS : 2 * BINS);
  assign qb    = posv[POS_W-1:ANG_W];
  assign wgt   = sel ? {1'b0, f} : (17'h10000 - {1'b0, f});
  assign av    = 17'((pa + (41'(GRAD_ZERO) << 23)) >> 24);
  assign rr    = a - 17'(q0) * 17'(GRAD_ZERO);
  assign vote  = (rr >= 17'(GRAD_ZERO)) ? q0 + 1'b1 : q0;
  assign hi    = (lo == K_W'(BINS - 1)) ? '0 : lo + 1'b1;

  assign pixel.ready = (state == F_IDLE);
  assign push_valid  = (state == F_PUSH);
  assign push_item   = '{lo: lo, hi: hi, vote_lo: vote_lo, vote_hi: vote_hi,
                         frame_start: fs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (pixel.valid) begin
            fs    <= pixel.frame_start;
            cnt   <= '0;
            rem   <= 48'(d2) << 32;
            root  <= '0;
            z     <= '0;
            spec  <= (dy_in == 0) || (dx_in == 0);
            if (dy_in == 0) begin
              spec_ang <= (dx_in < 0) ? 16'h8000 : 16'h0000;
            end else begin
              spec_ang <= (dy_in > 0) ? 16'h4000 : 16'hC000;
            end
            base  <= dx_in < 0;
            x     <= (dx_in < 0) ? -xi : xi;
            y     <= (dx_in < 0) ? -yi : yi;
            state <= F_ITER;
          end
        end
        F_ITER: begin
          if ((cnt < 5'(CORDIC_STEPS)) && !spec) begin
            if (y > 0) begin
              x <= x + sy;
              y <= y - sx;
              z <= z + at;
            end else begin
              x <= x - sy;
              y <= y + sx;
              z <= z - at;
            end
          end
          if (rem >= tryv) begin
            rem  <= rem - tryv;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            state <= F_POS;
          end
        end
        F_POS: begin
          lo    <= (qb >= (POS_W-ANG_W)'(BINS)) ? K_W'(qb - (POS_W-ANG_W)'(BINS))
                                                : K_W'(qb);
          f     <= posv[ANG_W-1:0];
          sel   <= 1'b0;
          state <= F_MUL;
        end
        F_MUL: begin
          pa    <= 41'(wgt) * 41'(root[MAG_W-1:0]);
          state <= F_DIV1;
        end
        F_DIV1: begin
          a     <= av;
          q0    <= VOTE_W'((28'(av) * 28'(RECIP)) >> RECIP_SH);
          state <= F_DIV2;
        end
        F_DIV2: begin
          if (sel) begin
            vote_hi <= (f == 16'd0) ? '0 : vote;
            state   <= F_PUSH;
          end else begin
            vote_lo <= vote;
            sel     <= 1'b1;
            state   <= F_MUL;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/hogih_queue.sv -----
// ----------------------------------------------------------------------------
// HOG integral histogram vote queue
// Two-entry queue of vote records between the front end and the back end.
// ----------------------------------------------------------------------------
module hogih_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  hogih_pkg::hogih_vote_t push_item,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output hogih_pkg::hogih_vote_t pop_item
);
  import hogih_pkg::*;

  hogih_vote_t entry [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entry[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- sv/hogih_back.sv -----
// ----------------------------------------------------------------------------
// HOG integral histogram back end
// Adds the votes into the row sums and the prior-row line store and sends
// one integral value per bin.
// ----------------------------------------------------------------------------
module hogih_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [10:0]            image_width,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  hogih_pkg::hogih_vote_t pop_item,
  hogih_bin_if.source            result
);
  import hogih_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_EX   = 2'd2;

  logic [1:0]        state;
  hogih_vote_t       item;
  logic [K_W-1:0]    k;
  logic [COL_W-1:0]  col;
  logic              first;
  logic [SUM_W-1:0]  rsum [BINS];
  logic              out_valid;
  logic [3:0]        out_bin;
  logic [SUM_W-1:0]  out_sum;
  logic              out_last;

  logic [WID_W-1:0]  w;
  logic [COL_W-1:0]  c1;
  logic              over;
  logic [ADDR_W-1:0] addr;
  logic [SUM_W-1:0]  rdata;
  logic [SUM_W-1:0]  v;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  total;
  logic              go;
  logic              we;
  logic [WID_W-1:0]  col_inc;

  always_comb begin
    if (image_width == 11'd0) begin
      w = WID_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(image_width);
    end
  end

  assign c1      = pop_item.frame_start ? '0 : col;
  assign over    = {1'b0, c1} >= w;
  assign addr    = ADDR_W'(k) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  assign v       = (k == item.lo) ? SUM_W'(item.vote_lo) :
                   (k == item.hi) ? SUM_W'(item.vote_hi) : '0;
  assign sum     = sat_add(rsum[k], v);
  assign total   = sat_add(first ? '0 : rdata, sum);
  assign go      = (state == B_EX) && (!out_valid || result.ready);
  assign we      = go;
  assign col_inc = {1'b0, col} + 1'b1;

  assign pop_ready           = (state == B_IDLE);
  assign result.valid        = out_valid;
  assign result.bin_index    = out_bin;
  assign result.integral_sum = out_sum;
  assign result.last_bin     = out_last;

  hogih_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (total),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      out_bin  <= BIN_IDX_W'(k);
      out_sum  <= total;
      out_last <= (k == K_W'(BINS - 1));
    end
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      first     <= 1'b1;
      k         <= '0;
      for (int j = 0; j < BINS; j++) begin
        rsum[j] <= '0;
      end
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            item  <= pop_item;
            k     <= '0;
            col   <= over ? '0 : c1;
            first <= over ? 1'b0 : (pop_item.frame_start ? 1'b1 : first);
            if (pop_item.frame_start || over) begin
              for (int j = 0; j < BINS; j++) begin
                rsum[j] <= '0;
              end
            end
            state <= B_RD;
          end
        end
        B_RD: begin
          state <= B_EX;
        end
        B_EX: begin
          if (go) begin
            if (k == K_W'(BINS - 1)) begin
              if (col_inc >= w) begin
                col   <= '0;
                first <= 1'b0;
                for (int j = 0; j < BINS; j++) begin
                  rsum[j] <= '0;
                end
              end else begin
                rsum[k] <= sum;
                col     <= col_inc[COL_W-1:0];
              end
              state <= B_IDLE;
            end else begin
              rsum[k] <= sum;
              k       <= k + 1'b1;
              state   <= B_RD;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/hog_orientation_integral_histogram_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HOG orientation integral histogram unit testbench
// Streams gradient pixels through the unit under several orientation modes,
// offsets and row widths, predicts every per-bin integral value and checks
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module hog_orientation_integral_histogram_unit_tb;
  import hogih_pkg::*;

  typedef struct packed {
    logic [3:0]  bin_index;
    logic [31:0] integral_sum;
    logic        last_bin;
  } bin_beat_t;

  localparam logic [3:0] ADDR_SIGNED = 4'd0;
  localparam logic [3:0] ADDR_OFFSET = 4'd4;
  localparam logic [3:0] ADDR_WIDTH  = 4'd8;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  hogih_pix_if pixel();
  hogih_bin_if result();

  hog_orientation_integral_histogram_unit dut (
    .clk(clk), .rst(rst), .pixel(pixel), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic        mdl_signed;
  logic [15:0] mdl_offset;
  logic [10:0] mdl_width;
  logic [31:0] mdl_line [DEPTH];
  logic [31:0] mdl_row [BINS];
  int unsigned mdl_col;
  logic        mdl_first_row;
  int unsigned max_written_col;

  bin_beat_t expected_bins[$];
  int mismatches = 0;
  bit stall_long;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("hog_orientation_integral_histogram_unit_tb: done, errors");
    $finish;
  end

  function automatic longint shr_rz(longint v, int s);
    return v >= 0 ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic logic [15:0] gradient_angle(int dx, int dy);
    longint x, y, z, nx, ny;
    logic [31:0] base;
    int steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    if (dy == 0) return dx >= 0 ? 16'd0 : 16'd32768;
    if (dx == 0) return dy > 0 ? 16'd16384 : 16'd49152;
    x = longint'(dx) * 65536;
    y = longint'(dy) * 65536;
    z = 0;
    base = 0;
    if (dx < 0) begin
      x = -x;
      y = -y;
      base = 32768;
    end
    for (int i = 0; i < 14; i++) begin
      if (y > 0) begin
        nx = x + shr_rz(y, i);
        ny = y - shr_rz(x, i);
        z += steps[i];
      end else begin
        nx = x - shr_rz(y, i);
        ny = y + shr_rz(x, i);
        z -= steps[i];
      end
      x = nx;
      y = ny;
    end
    return 16'(longint'(base) + z);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int unsigned clamped_width();
    if (mdl_width < 1) return 1;
    if (mdl_width > MAX_WIDTH) return MAX_WIDTH;
    return mdl_width;
  endfunction

  task automatic predict_histogram(logic [7:0] gx, logic [7:0] gy, logic fs);
    int dx, dy;
    int unsigned w, lo, hi, idx;
    logic [31:0] t, pos, f, v, above, total;
    logic [63:0] s, den, vhi, vlo;
    bin_beat_t b;
    dx = int'(gx) - 127;
    dy = int'(gy) - 127;
    w = clamped_width();
    if (fs) begin
      mdl_col = 0;
      foreach (mdl_row[k]) mdl_row[k] = 0;
      mdl_first_row = 1;
    end
    if (mdl_col >= w) begin
      mdl_col = 0;
      foreach (mdl_row[k]) mdl_row[k] = 0;
      mdl_first_row = 0;
    end
    t = gradient_angle(dx, dy) + mdl_offset;
    if (mdl_signed) t += 32768;
    t &= 32'hFFFF;
    pos = t * BINS * (mdl_signed ? 1 : 2);
    lo = (pos >> 16) % BINS;
    f = pos & 32'hFFFF;
    hi = (lo + 1) % BINS;
    s = isqrt(64'(dx * dx + dy * dy) << 32);
    den = 64'd127 << 24;
    vhi = (64'(f) * s + den / 2) / den;
    vlo = (64'(65536 - f) * s + den / 2) / den;
    for (int k = 0; k < BINS; k++) begin
      v = 0;
      idx = k * MAX_WIDTH + mdl_col;
      if (k == lo) v = vlo[31:0];
      else if (k == hi && f != 0) v = vhi[31:0];
      mdl_row[k] = sadd(mdl_row[k], v);
      above = mdl_first_row ? 32'd0 : mdl_line[idx];
      total = sadd(above, mdl_row[k]);
      mdl_line[idx] = total;
      b.bin_index = 4'(k);
      b.integral_sum = total;
      b.last_bin = (k == BINS - 1);
      expected_bins = {expected_bins, b};
    end
    mdl_col++;
    if (mdl_col >= w) begin
      mdl_col = 0;
      foreach (mdl_row[k]) mdl_row[k] = 0;
      mdl_first_row = 0;
    end
  endtask

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_pixel(logic [7:0] gx, logic [7:0] gy, logic fs);
    int g;
    g = short_gap();
    if (g > 0) begin
      pixel.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.grad_x <= gx;
    pixel.grad_y <= gy;
    pixel.frame_start <= fs;
    predict_histogram(gx, gy, fs);
    do @(posedge clk); while (!pixel.ready);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    pixel.valid <= 1'b0;
    while (expected_bins.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] a, logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (a)
      ADDR_SIGNED: mdl_signed = d[0];
      ADDR_OFFSET: mdl_offset = d[15:0];
      ADDR_WIDTH: begin
        mdl_width = d[10:0];
      end
      default: ;
    endcase
  endtask

  task automatic configure(logic sm, logic [15:0] off, logic [10:0] w);
    wait_idle();
    write_reg(ADDR_SIGNED, {31'd0, sm});
    write_reg(ADDR_OFFSET, {16'd0, off});
    write_reg(ADDR_WIDTH, {21'd0, w});
  endtask

  task automatic test_axes_and_extremes();
    logic [7:0] xs[6] = '{8'd0, 8'd127, 8'd255, 8'd128, 8'd126, 8'd200};
    configure(1'b0, 16'd0, 11'd5);
    send_pixel(8'd127, 8'd127, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_pixel(xs[i], 8'd127, 1'b0);
      send_pixel(8'd127, xs[i], 1'b0);
    end
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 1'b0);
  endtask

  task automatic test_signed_mode_and_offset();
    configure(1'b1, 16'hFFFF, 11'd3);
    send_pixel(8'd255, 8'd127, 1'b1);
    send_pixel(8'd0, 8'd127, 1'b0);
    send_pixel(8'd127, 8'd255, 1'b0);
    send_pixel(8'd127, 8'd0, 1'b0);
    send_pixel(8'd77, 8'd180, 1'b0);
  endtask

  task automatic test_width_one();
    configure(1'b0, 16'd1234, 11'd1);
    send_pixel(8'd255, 8'd255, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(8'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic random_frames(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      send_pixel(8'($urandom), 8'($urandom), cnt == 0 || $urandom_range(0, 60) == 0);
      cnt++;
    end
  endtask

  task automatic test_random();
    configure(1'b0, 16'd0, 11'd7);
    random_frames(90);
    configure(1'b1, 16'($urandom), 11'd4);
    random_frames(90);
    configure(1'b0, 16'($urandom), 11'd2);
    random_frames(80);
    configure(1'b1, 16'h8000, 11'd9);
    random_frames(80);
    configure(1'b0, 16'($urandom), 11'd1024);
    random_frames(60);
    configure(1'b1, 16'd0, 11'd0);
    random_frames(30);
  endtask

  task automatic test_wide_setting();
    configure(1'b0, 16'd0, 11'd2047);
    random_frames(20);
  endtask

  initial begin
    stall_long = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result.ready <= 1'b0;
      end else if (stall_long) begin
        result.ready <= 1'b1;
      end else if ($urandom_range(0, 150) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(20, 70)) @(posedge clk);
      end else begin
        result.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    bin_beat_t want, got;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        got.bin_index = result.bin_index;
        got.integral_sum = result.integral_sum;
        got.last_bin = result.last_bin;
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: bin %0d sum %0h last %0b",
                     got.bin_index, got.integral_sum, got.last_bin);
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp bin %0d sum %0h last %0b, got bin %0d sum %0h last %0b",
                       want.bin_index, want.integral_sum, want.last_bin,
                       got.bin_index, got.integral_sum, got.last_bin);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pixel.valid = 1'b0;
    pixel.grad_x = '0;
    pixel.grad_y = '0;
    pixel.frame_start = 1'b0;
    mdl_signed = 0;
    mdl_offset = 0;
    mdl_width = 11'd640;
    mdl_col = 0;
    mdl_first_row = 1;
    foreach (mdl_row[k]) mdl_row[k] = 0;
    foreach (mdl_line[i]) mdl_line[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axes_and_extremes();
    test_signed_mode_and_offset();
    test_width_one();
    test_random();
    test_wide_setting();
    wait_idle();
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("hog_orientation_integral_histogram_unit_tb: done, clean");
    end else begin
      $display("hog_orientation_integral_histogram_unit_tb: done, errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/hogih_pkg.sv
sv/hogih_if.sv
sv/hogih_ram.sv
sv/hogih_front.sv
sv/hogih_queue.sv
sv/hogih_back.sv
sv/hog_orientation_integral_histogram_unit.sv
dv/hog_orientation_integral_histogram_unit_tb.sv
